@@ rtl/mesh_neighbor_leader_table_core_defines.svh @@
// Assertion macros for the neighbor leader table core.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef MESH_NEIGHBOR_LEADER_TABLE_CORE_DEFINES_SVH
`define MESH_NEIGHBOR_LEADER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MNLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mnlt assertion failed");

// Next-cycle implication, disabled during reset.
`define MNLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mnlt assertion failed");

`endif

@@ rtl/mnlt_pkg.sv @@
// Types, constants and helper functions for the neighbor leader table.
// No dependencies; used by the row memory and the core.
package mnlt_pkg;

  localparam int unsigned MacW   = 48;
  localparam int unsigned IdW    = 8;
  localparam int unsigned HopW   = 8;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [HopW-1:0]   HOP_MAX    = 8'd200;
  localparam logic [HopW-1:0]   HOP_ORPHAN = 8'd100;
  localparam logic [ScoreW-1:0] SCORE_NEW  = 16'd90;
  localparam logic signed [ScoreW+1:0] SCORE_LEAD = 18'sd100;

  localparam logic [CfgIdxW-1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OWN_ID   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GATE_ID  = 2'd2;

  typedef struct packed {
    logic [MacW-1:0] src_mac;
    logic [MacW-1:0] target_mac;
    logic [IdW-1:0]  sender_id;
    logic [HopW-1:0] sender_hops;
    logic [IdW-1:0]  final_dest_id;
  } in_item_t;

  typedef struct packed {
    logic            forward_valid;
    logic [MacW-1:0] forward_mac;
    logic [HopW-1:0] forward_hops;
    logic [IdW-1:0]  forward_sender;
    logic            from_leader;
    logic            leader_present;
    logic [HopW-1:0] own_hops;
  } out_item_t;

  // One table row as held in memory.
  typedef struct packed {
    logic [MacW-1:0]   mac;
    logic [HopW-1:0]   hops;
    logic [ScoreW-1:0] score;
  } row_t;

  function automatic logic [ScoreW-1:0] sat16(input logic signed [ScoreW+1:0] v);
    logic [ScoreW-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'h7fff;
    end else if (v < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[ScoreW-1:0];
    end
    return r;
  endfunction

  function automatic logic [HopW-1:0] hop_plus_one(input logic [HopW-1:0] h);
    logic [HopW-1:0] r;
    if (h >= HOP_MAX) begin
      r = HOP_MAX;
    end else begin
      r = h + 8'd1;
    end
    return r;
  endfunction

endpackage

@@ rtl/mnlt_row_mem.sv @@
// Single-port-write, single-port-read row memory with registered read data.
// Depends on mnlt_pkg for the row type.
module mnlt_row_mem #(
  parameter int unsigned Rows = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  mnlt_pkg::row_t    wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output mnlt_pkg::row_t    rdata_o
);
  import mnlt_pkg::*;

  row_t mem [Rows];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mesh_neighbor_leader_table_core.sv @@
// Neighbor leader table core: one result per overheard packet, one packet at a time.
// Flow per packet: each row is read and compared in turn, then a finish step; a known sender
// adds an update step and either a lowering step that changes nothing or, when its score passes
// 100, a read-and-lower pass over every row.
// A new packet is taken only once the last one has finished; a held result stalls the finish.
// Reset (async, active low) frees all rows, clears the leader, sets hops to 100.
module mesh_neighbor_leader_table_core #(
  parameter int unsigned TABLE_ROWS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mnlt_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mnlt_pkg::MacW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mnlt_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mnlt_pkg::out_item_t               out_data_o
);
  import mnlt_pkg::*;
  `include "mesh_neighbor_leader_table_core_defines.svh"

  localparam int unsigned AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ROWS - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_INS  = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_LRD  = 7'b0100000,
    S_LWR  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic fin;

  logic [MacW-1:0] own_mac_q;
  logic [IdW-1:0]  own_id_q, gate_id_q;

  logic [TABLE_ROWS-1:0] row_valid_q, row_valid_d;
  logic [AW-1:0] leader_row_q, leader_row_d;
  logic          leader_valid_q, leader_valid_d;
  logic [HopW-1:0] hop_q, hop_d;
  logic [MacW-1:0] lmac_q, lmac_d;

  in_item_t item_q;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] hit_q, hit_d, free_q, free_d;
  logic          free_found_q, free_found_d;
  logic [ScoreW-1:0] hit_score_q, hit_score_d;
  logic [ScoreW-1:0] delta_q, delta_d;

  logic out_valid_q;
  out_item_t out_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  row_t          mem_wdata, mem_rdata;

  mnlt_row_mem #(.Rows(TABLE_ROWS), .AddrW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  logic is_leader;
  logic [HopW-1:0] upd_hop;
  logic [ScoreW-1:0] upd_score, low_score;
  logic signed [ScoreW+1:0] upd_sum;
  logic fwd;

  assign is_leader = leader_valid_q && (leader_row_q == hit_q);
  assign upd_hop   = is_leader ? hop_plus_one(item_q.sender_hops) : hop_q;
  assign upd_sum   = $signed({{2{hit_score_q[ScoreW-1]}}, hit_score_q})
                   + $signed({10'd0, upd_hop}) - $signed({10'd0, item_q.sender_hops})
                   + 18'sd1;
  assign upd_score = sat16(upd_sum);
  assign low_score = sat16($signed({{2{mem_rdata.score[ScoreW-1]}}, mem_rdata.score})
                         - $signed({2'b00, delta_q}));

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    hit_d          = hit_q;
    free_d         = free_q;
    free_found_d   = free_found_q;
    hit_score_d    = hit_score_q;
    delta_d        = delta_q;
    row_valid_d    = row_valid_q;
    leader_row_d   = leader_row_q;
    leader_valid_d = leader_valid_q;
    hop_d          = hop_q;
    lmac_d         = lmac_q;
    mem_we         = 1'b0;
    mem_waddr      = cnt_q;
    mem_wdata      = '{mac: item_q.src_mac, hops: item_q.sender_hops, score: SCORE_NEW};
    mem_raddr      = cnt_q;
    fin            = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d        = '0;
          free_found_d = 1'b0;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (row_valid_q[cnt_q] && (mem_rdata.mac == item_q.src_mac)) begin
          hit_d       = cnt_q;
          hit_score_d = mem_rdata.score;
          state_d     = S_UPD;
        end else begin
          if (!row_valid_q[cnt_q] && !free_found_q) begin
            free_d       = cnt_q;
            free_found_d = 1'b1;
          end
          if (cnt_q == LAST) begin
            state_d = S_INS;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_INS: begin
        fin = 1'b1;
        if (free_found_q && (!out_valid_q || out_ready_i)) begin
          mem_we    = 1'b1;
          mem_waddr = free_q;
          row_valid_d[free_q] = (item_q.sender_id != '0);
          // A reused row still backs a stale leader pointer.
          if (leader_row_q == free_q) begin
            lmac_d = item_q.src_mac;
          end
          if (!leader_valid_q && (item_q.sender_hops < hop_q)) begin
            leader_valid_d = 1'b1;
            leader_row_d   = free_q;
            hop_d          = hop_plus_one(item_q.sender_hops);
            lmac_d         = item_q.src_mac;
          end
        end
      end
      S_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = hit_q;
        mem_wdata.score = upd_score;
        hop_d     = upd_hop;
        if ($signed({{2{upd_score[ScoreW-1]}}, upd_score}) > SCORE_LEAD) begin
          if (!is_leader) begin
            leader_valid_d = 1'b1;
            leader_row_d   = hit_q;
            hop_d          = hop_plus_one(item_q.sender_hops);
            lmac_d         = item_q.src_mac;
          end
          delta_d = upd_score - 16'd100;
          cnt_d   = '0;
          state_d = S_LRD;
        end else begin
          state_d = S_LWR;
          cnt_d   = LAST;
          delta_d = '0;
        end
      end
      S_LRD: begin
        state_d = S_LWR;
      end
      S_LWR: begin
        if (delta_q != '0 && row_valid_q[cnt_q]) begin
          mem_we    = 1'b1;
          mem_wdata = '{mac: mem_rdata.mac, hops: mem_rdata.hops, score: low_score};
          if (low_score[ScoreW-1]) begin
            row_valid_d[cnt_q] = 1'b0;
            if (leader_valid_q && (leader_row_q == cnt_q)) begin
              leader_valid_d = 1'b0;
              hop_d          = HOP_ORPHAN;
            end
          end
        end
        if (cnt_q == LAST) begin
          state_d = S_INS;
          free_found_d = 1'b0;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_LRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Result stage: the insert state doubles as the finishing step.
    if (fin) begin
      if (!out_valid_q || out_ready_i) begin
        state_d = S_IDLE;
      end else begin
        row_valid_d    = row_valid_q;
        leader_valid_d = leader_valid_q;
        leader_row_d   = leader_row_q;
        hop_d          = hop_q;
        lmac_d         = lmac_q;
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign fwd = (item_q.target_mac == own_mac_q) && leader_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      row_valid_q    <= '0;
      leader_row_q   <= '0;
      leader_valid_q <= 1'b0;
      hop_q          <= HOP_ORPHAN;
      out_valid_q    <= 1'b0;
      own_mac_q      <= '0;
      own_id_q       <= '0;
      gate_id_q      <= '0;
      cnt_q          <= '0;
      free_found_q   <= 1'b0;
    end else begin
      state_q        <= state_d;
      row_valid_q    <= row_valid_d;
      leader_row_q   <= leader_row_d;
      leader_valid_q <= leader_valid_d;
      hop_q          <= hop_d;
      cnt_q          <= cnt_d;
      free_found_q   <= free_found_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_MAC: own_mac_q <= cfg_wdata_i;
          CFG_OWN_ID:  own_id_q  <= cfg_wdata_i[IdW-1:0];
          CFG_GATE_ID: gate_id_q <= cfg_wdata_i[IdW-1:0];
          default: ;
        endcase
      end
      if (fin && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    hit_q       <= hit_d;
    free_q      <= free_d;
    hit_score_q <= hit_score_d;
    delta_q     <= delta_d;
    lmac_q      <= lmac_d;
    if (fin && (!out_valid_q || out_ready_i)) begin
      out_q.forward_valid  <= fwd;
      out_q.forward_mac    <= !fwd ? '0 :
                              (item_q.final_dest_id == gate_id_q) ? lmac_d : item_q.target_mac;
      out_q.forward_hops   <= fwd ? hop_d : '0;
      out_q.forward_sender <= fwd ? own_id_q : '0;
      out_q.from_leader    <= leader_valid_d && (lmac_d == item_q.src_mac);
      out_q.leader_present <= leader_valid_d;
      out_q.own_hops       <= hop_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MNLT_ASSERT_NOW(a_hop_range, 1'b1, hop_q <= HOP_MAX)
  `MNLT_ASSERT_NEXT(a_accept_starts_scan, in_valid_i && in_ready_o, state_q == S_RD)
  `MNLT_ASSERT_NEXT(a_orphan_hops,
    state_q == S_LWR && delta_q != '0 && row_valid_q[cnt_q] && low_score[ScoreW-1] &&
    leader_valid_q && leader_row_q == cnt_q,
    !leader_valid_q && hop_q == HOP_ORPHAN)

endmodule

@@ tb/tb_mesh_neighbor_leader_table_core.sv @@
// Self-checking testbench for the mesh neighbor leader table core.
// Depends on mnlt_pkg and mesh_neighbor_leader_table_core; predicts each result in SV.
module tb_mesh_neighbor_leader_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mnlt_pkg::*;

  localparam int Rows = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [MacW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;

  mesh_neighbor_leader_table_core #(.TABLE_ROWS(Rows)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state for the neighbor table.
  logic [MacW-1:0] cur_own_mac = '0;
  logic [IdW-1:0] cur_own_id = '0;
  logic [IdW-1:0] cur_gate_id = '0;
  logic [IdW-1:0] nb_node[Rows];
  logic [MacW-1:0] nb_mac[Rows];
  logic [HopW-1:0] nb_hops[Rows];
  int nb_score[Rows];
  int lead_idx = 0;
  bit lead_ok = 0;
  logic [HopW-1:0] my_hops = HOP_ORPHAN;

  in_item_t pending_pkts[$];
  out_item_t expected_fwd[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_fwd = 0;
  int n_lead = 0;

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [HopW-1:0] hop_inc(logic [HopW-1:0] h);
    return (h >= HOP_MAX) ? HOP_MAX : h + 8'd1;
  endfunction

  function automatic out_item_t predict_packet(in_item_t p);
    out_item_t r;
    int hit;
    bit is_lead;
    int excess;
    logic [MacW-1:0] lmac;
    hit = -1;
    r = '0;
    for (int i = 0; i < Rows; i++)
      if (hit < 0 && nb_node[i] != 0 && nb_mac[i] == p.src_mac) hit = i;
    if (hit < 0) begin
      for (int i = 0; i < Rows; i++) begin
        if (nb_node[i] == 0) begin
          nb_node[i] = p.sender_id;
          nb_hops[i] = p.sender_hops;
          nb_score[i] = 90;
          nb_mac[i] = p.src_mac;
          if (!lead_ok && p.sender_hops < my_hops) begin
            lead_ok = 1;
            lead_idx = i;
            my_hops = hop_inc(p.sender_hops);
          end
          break;
        end
      end
    end else begin
      is_lead = lead_ok && lead_idx == hit;
      nb_hops[hit] = p.sender_hops;
      if (is_lead) my_hops = hop_inc(p.sender_hops);
      nb_score[hit] = clip16(nb_score[hit] + int'(my_hops) - int'(p.sender_hops) + 1);
      if (nb_score[hit] > 100) begin
        if (!is_lead) begin
          lead_ok = 1;
          lead_idx = hit;
          my_hops = hop_inc(p.sender_hops);
        end
        excess = nb_score[hit] - 100;
        for (int i = 0; i < Rows; i++) begin
          if (nb_node[i] != 0) begin
            nb_score[i] = clip16(nb_score[i] - excess);
            if (nb_score[i] < 0) begin
              nb_node[i] = 0;
              if (lead_ok && lead_idx == i) begin
                lead_ok = 0;
                my_hops = HOP_ORPHAN;
              end
            end
          end
        end
      end
    end
    lmac = lead_ok ? nb_mac[lead_idx] : '0;
    r.forward_valid = (p.target_mac == cur_own_mac) && lead_ok;
    if (r.forward_valid) begin
      r.forward_mac = (p.final_dest_id == cur_gate_id) ? lmac : p.target_mac;
      r.forward_hops = my_hops;
      r.forward_sender = cur_own_id;
    end
    r.from_leader = lead_ok && lmac == p.src_mac;
    r.leader_present = lead_ok;
    r.own_hops = my_hops;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // Ready and valid as seen at the last rising edge, for the driver and the receiver.
  logic in_ready_q = 1'b0;
  logic out_valid_q = 1'b0;
  always @(posedge clk_i) out_valid_q <= out_valid_o;

  // Driver: one packet per transaction, random gap before each.
  int gap_in = 0;
  bit send_hold = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_q) begin
        in_valid_i <= 1'b0;
        gap_in = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap_in = 0;
      end else if (!in_valid_i && !send_hold && pending_pkts.size() > 0) begin
        if (gap_in > 0) gap_in--;
        else begin
          in_data_i <= pending_pkts[0];
          expected_fwd.push_back(predict_packet(pending_pkts.pop_front()));
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  int gap_out = 0;
  always @(posedge clk_i) begin
    in_ready_q <= in_ready_o;
    if (out_valid_o && out_ready_i) begin
      n_checked++;
      if (expected_fwd.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(out_data_o.forward_mac), 64'd0);
      end else begin
        out_item_t e;
        e = expected_fwd.pop_front();
        if (e.forward_valid) n_fwd++;
        if (e.leader_present) n_lead++;
        if (out_data_o.forward_valid !== e.forward_valid)
          report_mismatch("forward_valid", 64'(out_data_o.forward_valid),
                          64'(e.forward_valid));
        if (out_data_o.forward_mac !== e.forward_mac)
          report_mismatch("forward_mac", 64'(out_data_o.forward_mac), 64'(e.forward_mac));
        if (out_data_o.forward_hops !== e.forward_hops)
          report_mismatch("forward_hops", 64'(out_data_o.forward_hops), 64'(e.forward_hops));
        if (out_data_o.forward_sender !== e.forward_sender)
          report_mismatch("forward_sender", 64'(out_data_o.forward_sender),
                          64'(e.forward_sender));
        if (out_data_o.from_leader !== e.from_leader)
          report_mismatch("from_leader", 64'(out_data_o.from_leader), 64'(e.from_leader));
        if (out_data_o.leader_present !== e.leader_present)
          report_mismatch("leader_present", 64'(out_data_o.leader_present),
                          64'(e.leader_present));
        if (out_data_o.own_hops !== e.own_hops)
          report_mismatch("own_hops", 64'(out_data_o.own_hops), 64'(e.own_hops));
      end
    end
  end

  // Receiver stalls: ready drops for a random count after each transaction.
  always @(negedge clk_i) begin
    if (out_valid_q && out_ready_i) begin
      gap_out = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap_out = 0;
      out_ready_i <= (gap_out == 0);
    end else if (gap_out > 0) begin
      gap_out--;
      out_ready_i <= (gap_out == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // A small pool of MACs so senders repeat and scores climb.
  logic [MacW-1:0] mac_pool[24];

  function automatic in_item_t make_pkt(logic [MacW-1:0] s, logic [MacW-1:0] t,
                                         logic [7:0] id, logic [7:0] h, logic [7:0] d);
    in_item_t p;
    p.src_mac = s;
    p.target_mac = t;
    p.sender_id = id;
    p.sender_hops = h;
    p.final_dest_id = d;
    return p;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [MacW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_OWN_MAC) cur_own_mac = val;
    else if (idx == CFG_OWN_ID) cur_own_id = val[IdW-1:0];
    else cur_gate_id = val[IdW-1:0];
  endtask

  task automatic drain();
    wait (pending_pkts.size() == 0 && !in_valid_i && expected_fwd.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic in_item_t random_pkt();
    logic [MacW-1:0] s, t;
    int k;
    k = $urandom_range(0, 99);
    s = (k < 85) ? mac_pool[$urandom_range(0, 23)] : 48'({$urandom, $urandom});
    k = $urandom_range(0, 99);
    if (k < 45) t = cur_own_mac;
    else if (k < 60) t = mac_pool[$urandom_range(0, 23)];
    else t = 48'({$urandom, $urandom});
    k = $urandom_range(0, 99);
    return make_pkt(s, t,
                    (k < 8) ? 8'd0 : 8'($urandom_range(1, 255)),
                    (k < 70) ? 8'($urandom_range(0, 12)) : 8'($urandom),
                    ($urandom_range(0, 1) == 0) ? cur_gate_id : 8'($urandom));
  endfunction

  initial begin
    for (int i = 0; i < Rows; i++) begin
      nb_node[i] = '0;
      nb_mac[i] = '0;
      nb_hops[i] = '0;
      nb_score[i] = 0;
    end
    for (int i = 0; i < 24; i++) mac_pool[i] = 48'({$urandom, $urandom});
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: registers at their extremes, directed corner cases.
    write_reg(CFG_OWN_MAC, '1);
    write_reg(CFG_OWN_ID, 8'hff);
    write_reg(CFG_GATE_ID, 8'h00);
    pending_pkts.push_back(make_pkt(mac_pool[2], '1, 8'd5, 8'd255, 8'd0));  // hops not below
    pending_pkts.push_back(make_pkt(mac_pool[3], '0, 8'd0, 8'd3, 8'd0));    // id zero leader
    pending_pkts.push_back(make_pkt(mac_pool[4], '1, 8'd7, 8'd0, 8'd0));    // forward to gate
    pending_pkts.push_back(make_pkt(mac_pool[4], '1, 8'd7, 8'd0, 8'hff));   // forward to target
    pending_pkts.push_back(make_pkt(mac_pool[3], '1, 8'd0, 8'd255, 8'd0));  // first leader's MAC
    pending_pkts.push_back(make_pkt(mac_pool[4], 48'h1, 8'd7, 8'd199, 8'd0));
    for (int i = 0; i < 18; i++)  // overfill the table
      pending_pkts.push_back(make_pkt(mac_pool[5 + i], '1, 8'(i + 1), 8'd255, 8'd0));
    pending_pkts.push_back(make_pkt('0, '1, 8'hff, 8'd200, 8'd0));
    drain();

    // Random phases with different register settings; one full pause each.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_OWN_MAC, (ph == 1) ? 48'h0 : mac_pool[$urandom_range(0, 23)]);
      write_reg(CFG_OWN_ID, (ph == 1) ? 8'h00 : 8'($urandom));
      write_reg(CFG_GATE_ID, (ph == 2) ? 8'hff : 8'($urandom));
      for (int n = 0; n < 310; n++) begin
        pending_pkts.push_back(random_pkt());
        if (n == 150) begin
          wait (pending_pkts.size() == 0);
          send_hold = 1;
          wait (!in_valid_i && expected_fwd.size() == 0);
          send_hold = 0;
        end
      end
      drain();
    end

    $display("Checked %0d results: %0d forwarded, %0d with a leader present.",
             n_checked, n_fwd, n_lead);
    if (n_errors == 0) begin
      $display("mesh_neighbor_leader_table_core verification clean");
    end else begin
      $display("mesh_neighbor_leader_table_core verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("mesh_neighbor_leader_table_core verification failed");
    $finish;
  end

endmodule
